// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("property violated");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- hw/rtl/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Cartesian / polar converter package
// Shared constants, the arctangent table and the control types.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int ITERATIONS_DEF = 16;
   localparam int GUARD          = 24;
   localparam int ATAN_LEN       = 32;

   localparam logic [31:0] KINV = 32'd2608131496;

   localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef enum logic {
      OP_TO_POLAR = 1'b0,
      OP_TO_CART  = 1'b1
   } op_type;

   typedef struct packed {
      op_type op;
      logic   zero;
   } ctl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/cpc_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// CORDIC micro-rotation stage
// One registered shift-and-add rotation step, shared by both conversions.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_cordic_stage
   import cpc_pkg::*;
#(
   parameter int XW    = 43,
   parameter int STAGE = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic                 in_valid,
   input  wire ctl_type              in_ctl,
   input  wire logic signed [XW-1:0] in_x,
   input  wire logic signed [XW-1:0] in_y,
   input  wire logic        [31:0]   in_z,
   output logic                      out_valid,
   output ctl_type                   out_ctl,
   output logic signed [XW-1:0]      out_x,
   output logic signed [XW-1:0]      out_y,
   output logic        [31:0]        out_z
);

   localparam logic [31:0] ATAN = ATAN_TAB[STAGE];

   logic                 valid_ff;
   ctl_type              ctl_ff;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic        [31:0]   z_ff, z_in;
   logic signed [XW-1:0] dx, dy;
   logic                 ccw;

   // Rotation drives the angle toward zero, vectoring drives y toward zero.
   always_comb begin
      dx  = in_y >>> STAGE;
      dy  = in_x >>> STAGE;
      ccw = (in_ctl.op == OP_TO_CART) ? ~in_z[31] : in_y[XW-1];
      if (ccw) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ctl_ff <= in_ctl;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/cartesian_polar_converter_unit.sv -----
// ----------------------------------------------------------------------------
// Cartesian / polar converter unit
// Pipelined CORDIC converting points to magnitude and angle, or back.
// ----------------------------------------------------------------------------
// Each request beat carries an operation and both operand sets. Operation
// OP_TO_POLAR turns (x_coord, y_coord) into a rounded magnitude and a
// full-circle binary angle; OP_TO_CART turns (radius, angle) into a
// saturated point and flags saturation on overflow. Fields that do not
// belong to the operation read as zero.
// The pipeline has ITERATIONS + 5 register stages: an input stage with the
// gain multiply, a setup stage, one stage per CORDIC iteration, a split
// gain multiply and its final sum, and the response register. A request
// beat passes through these stages in order to become a response beat, and
// one beat can be taken every cycle unless a stalled response has filled
// the pipeline.
// Each stage moves forward whenever it is empty or the stage after it
// moves, so a stalled response only holds the stages that are full; empty
// stages keep filling and req_ready drops once the whole pipeline is full.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cartesian_polar_converter_unit
   import cpc_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int ITERATIONS = ITERATIONS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_operation,
   input  wire logic signed [DATA_WIDTH-1:0] req_x_coord,
   input  wire logic signed [DATA_WIDTH-1:0] req_y_coord,
   input  wire logic        [DATA_WIDTH-1:0] req_radius,
   input  wire logic signed [DATA_WIDTH-1:0] req_angle,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_x,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_y,
   output logic        [DATA_WIDTH-1:0]      rsp_out_radius,
   output logic signed [DATA_WIDTH-1:0]      rsp_out_angle,
   output logic                              rsp_overflow
);

   localparam int W   = DATA_WIDTH;
   localparam int XW  = W + GUARD + 3;
   localparam int UW  = XW - 1;
   localparam int XLO = (UW + 1) / 2;
   localparam int XHI = UW - XLO;
   localparam int ZSH = 32 - W;
   localparam int PW  = W + 32;
   localparam int MW  = UW + 33;

   localparam logic [PW:0]            XRND = (PW + 1)'(1) << (31 - GUARD);
   localparam logic signed [XW-1:0]   HALF = XW'(1) << (GUARD - 1);
   localparam logic [32:0]            ARND = 33'((2 ** ZSH) / 2);
   localparam logic [MW-1:0]          MRND = MW'(1) << 31;
   localparam logic [UW+1:0]          RRND = (UW + 2)'(1) << (GUARD - 1);
   localparam logic signed [31:0]     QTR_POS = 32'sh4000_0000;
   localparam logic signed [31:0]     QTR_NEG = -QTR_POS;
   localparam logic signed [W+2:0]    SMAX_E = {4'b0000, {(W - 1){1'b1}}};
   localparam logic signed [W+2:0]    SMIN_E = {4'b1111, {(W - 1){1'b0}}};
   localparam logic signed [W-1:0]    SMAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic signed [W-1:0]    SMIN = {1'b1, {(W - 1){1'b0}}};

   // Saturate a rounded result to the signed range; the top bit is the flag.
   function automatic logic [W:0] sat_out(input logic signed [W+2:0] v);
      logic [W:0] res;
      if (v > SMAX_E) begin
         res = {1'b1, SMAX};
      end else if (v < SMIN_E) begin
         res = {1'b1, SMIN};
      end else begin
         res = {1'b0, v[W-1:0]};
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- enables
   logic en_s1, en_s2, en_pa, en_pb, en_out;
   logic c_en [ITERATIONS];

   // ------------------------------------------------------ input stage (s1)
   logic                s1_valid_ff;
   ctl_type             s1_ctl_ff, s1_ctl_in;
   logic signed [W-1:0] s1_x_ff, s1_y_ff, s1_a_ff;
   logic [PW-1:0]       s1_prod_ff, s1_prod_in;

   always_comb begin
      s1_ctl_in.op   = op_type'(req_operation);
      s1_ctl_in.zero = (req_x_coord == '0) && (req_y_coord == '0);
      s1_prod_in     = PW'(req_radius) * PW'(KINV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en_s1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s1) begin
         s1_ctl_ff  <= s1_ctl_in;
         s1_x_ff    <= req_x_coord;
         s1_y_ff    <= req_y_coord;
         s1_a_ff    <= req_angle;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // ------------------------------------------------------ setup stage (s2)
   logic                 s2_valid_ff;
   ctl_type              s2_ctl_ff;
   logic signed [XW-1:0] s2_x_ff, s2_x_in, s2_y_ff, s2_y_in;
   logic        [31:0]   s2_z_ff, s2_z_in;
   logic signed [XW-1:0] px, py, cx0;
   logic signed [31:0]   za;
   logic [PW:0]          xsum;
   logic                 fold;

   always_comb begin
      px   = XW'(s1_x_ff) <<< GUARD;
      py   = XW'(s1_y_ff) <<< GUARD;
      za   = 32'(s1_a_ff) <<< ZSH;
      fold = (za > QTR_POS) || (za < QTR_NEG);
      xsum = {1'b0, s1_prod_ff} + XRND;
      cx0  = XW'(xsum[PW:32-GUARD]);
      if (s1_ctl_ff.op == OP_TO_CART) begin
         s2_x_in = fold ? -cx0 : cx0;
         s2_y_in = '0;
         s2_z_in = fold ? {~za[31], za[30:0]} : za;
      end else if (s1_x_ff[W-1]) begin
         // Left half plane: turn the vector by a half turn first.
         s2_x_in = -px;
         s2_y_in = -py;
         s2_z_in = 32'h8000_0000;
      end else begin
         s2_x_in = px;
         s2_y_in = py;
         s2_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en_s2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_s2) begin
         s2_ctl_ff <= s1_ctl_ff;
         s2_x_ff   <= s2_x_in;
         s2_y_ff   <= s2_y_in;
         s2_z_ff   <= s2_z_in;
      end
   end

   // ---------------------------------------------------------- CORDIC chain
   logic                 c_valid [ITERATIONS];
   ctl_type              c_ctl   [ITERATIONS];
   logic signed [XW-1:0] c_x     [ITERATIONS];
   logic signed [XW-1:0] c_y     [ITERATIONS];
   logic        [31:0]   c_z     [ITERATIONS];

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
      if (k == 0) begin : g_first
         assign c_en[k] = !c_valid[k] || ((ITERATIONS == 1) ? en_pa : c_en[k + 1]);
         cpc_cordic_stage #(
            .XW    (XW),
            .STAGE (k)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .enable    (c_en[k]),
            .in_valid  (s2_valid_ff),
            .in_ctl    (s2_ctl_ff),
            .in_x      (s2_x_ff),
            .in_y      (s2_y_ff),
            .in_z      (s2_z_ff),
            .out_valid (c_valid[k]),
            .out_ctl   (c_ctl[k]),
            .out_x     (c_x[k]),
            .out_y     (c_y[k]),
            .out_z     (c_z[k])
         );
      end else begin : g_next
         if (k == ITERATIONS - 1) begin : g_last
            assign c_en[k] = !c_valid[k] || en_pa;
         end else begin : g_mid
            assign c_en[k] = !c_valid[k] || c_en[k + 1];
         end
         cpc_cordic_stage #(
            .XW    (XW),
            .STAGE (k)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .enable    (c_en[k]),
            .in_valid  (c_valid[k - 1]),
            .in_ctl    (c_ctl[k - 1]),
            .in_x      (c_x[k - 1]),
            .in_y      (c_y[k - 1]),
            .in_z      (c_z[k - 1]),
            .out_valid (c_valid[k]),
            .out_ctl   (c_ctl[k]),
            .out_x     (c_x[k]),
            .out_y     (c_y[k]),
            .out_z     (c_z[k])
         );
      end
   end

   // ------------------------------------------- gain multiply, split (pa)
   logic                 pa_valid_ff;
   ctl_type              pa_ctl_ff;
   logic [XLO+31:0]      pa_pl_ff, pa_pl_in;
   logic [XHI+31:0]      pa_ph_ff, pa_ph_in;
   logic [W-1:0]         pa_ang_ff, pa_ang_in;
   logic [W:0]           pa_sx_ff, pa_sx_in, pa_sy_ff, pa_sy_in;
   logic [UW-1:0]        xu;
   logic [32:0]          zr;
   logic signed [XW-1:0] xr, yr;

   always_comb begin
      xu        = c_x[ITERATIONS-1][XW-1] ? '0 : c_x[ITERATIONS-1][UW-1:0];
      pa_pl_in  = (XLO + 32)'(xu[XLO-1:0]) * (XLO + 32)'(KINV);
      pa_ph_in  = (XHI + 32)'(xu[UW-1:XLO]) * (XHI + 32)'(KINV);
      zr        = {1'b0, c_z[ITERATIONS-1]} + ARND;
      pa_ang_in = zr[ZSH +: W];
      xr        = (c_x[ITERATIONS-1] + HALF) >>> GUARD;
      yr        = (c_y[ITERATIONS-1] + HALF) >>> GUARD;
      pa_sx_in  = sat_out(xr[W+2:0]);
      pa_sy_in  = sat_out(yr[W+2:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff <= 1'b0;
      end else if (en_pa) begin
         pa_valid_ff <= c_valid[ITERATIONS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en_pa) begin
         pa_ctl_ff <= c_ctl[ITERATIONS-1];
         pa_pl_ff  <= pa_pl_in;
         pa_ph_ff  <= pa_ph_in;
         pa_ang_ff <= pa_ang_in;
         pa_sx_ff  <= pa_sx_in;
         pa_sy_ff  <= pa_sy_in;
      end
   end

   // ------------------------------------------------ partial product sum (pb)
   logic            pb_valid_ff;
   ctl_type         pb_ctl_ff;
   logic [UW:0]     pb_m_ff, pb_m_in;
   logic [W-1:0]    pb_ang_ff;
   logic [W:0]      pb_sx_ff, pb_sy_ff;
   logic [MW-1:0]   msum;

   always_comb begin
      msum    = (MW'(pa_ph_ff) << XLO) + MW'(pa_pl_ff) + MRND;
      pb_m_in = msum[MW-1:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pb_valid_ff <= 1'b0;
      end else if (en_pb) begin
         pb_valid_ff <= pa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_pb) begin
         pb_ctl_ff <= pa_ctl_ff;
         pb_m_ff   <= pb_m_in;
         pb_ang_ff <= pa_ang_ff;
         pb_sx_ff  <= pa_sx_ff;
         pb_sy_ff  <= pa_sy_ff;
      end
   end

   // --------------------------------------------------- response register
   logic                out_valid_ff;
   ctl_type             out_ctl_ff;
   logic signed [W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [W-1:0]        out_rad_ff, out_rad_in;
   logic signed [W-1:0] out_ang_ff, out_ang_in;
   logic                out_ovf_ff, out_ovf_in;
   logic [UW+1:0]       rr;
   logic [W-1:0]        rad;

   always_comb begin
      rr  = (UW + 2)'(pb_m_ff) + RRND;
      rad = (|rr[UW+1:GUARD+W]) ? '1 : rr[GUARD +: W];
      out_x_in   = '0;
      out_y_in   = '0;
      out_rad_in = '0;
      out_ang_in = '0;
      out_ovf_in = 1'b0;
      if (pb_ctl_ff.op == OP_TO_CART) begin
         out_x_in   = pb_sx_ff[W-1:0];
         out_y_in   = pb_sy_ff[W-1:0];
         out_ovf_in = pb_sx_ff[W] | pb_sy_ff[W];
      end else if (!pb_ctl_ff.zero) begin
         out_rad_in = rad;
         out_ang_in = pb_ang_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en_out) begin
         out_valid_ff <= pb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_ctl_ff <= pb_ctl_ff;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         out_rad_ff <= out_rad_in;
         out_ang_ff <= out_ang_in;
         out_ovf_ff <= out_ovf_in;
      end
   end

   // A stage takes a new beat when it is empty or its successor moves on.
   assign en_out    = !out_valid_ff || rsp_ready;
   assign en_pb     = !pb_valid_ff || en_out;
   assign en_pa     = !pa_valid_ff || en_pb;
   assign en_s2     = !s2_valid_ff || c_en[0];
   assign en_s1     = !s1_valid_ff || en_s2;
   assign req_ready = en_s1;

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_out_radius = out_rad_ff;
   assign rsp_out_angle  = out_ang_ff;
   assign rsp_overflow   = out_ovf_ff;

   // ------------------------------------------------------------ assertions
   `ASSERT_PROP(a_accept_fills_s1, clock, reset, (req_valid && req_ready) |=> s1_valid_ff)
   `ASSERT_PROP(a_s2_holds_on_stall, clock, reset, (s2_valid_ff && !en_s2) |=> s2_valid_ff)
   `ASSERT_NEVER(a_polar_no_overflow, clock, reset,
                 rsp_valid && (out_ctl_ff.op == OP_TO_POLAR) && rsp_overflow)
   `ASSERT_PROP(a_overflow_saturates, clock, reset,
                (rsp_valid && rsp_overflow) |-> (rsp_out_x == SMAX || rsp_out_x == SMIN ||
                                                 rsp_out_y == SMAX || rsp_out_y == SMIN))

endmodule

`default_nettype wire

// ----- bench/cartesian_polar_converter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Cartesian / polar converter unit testbench
// Drives conversion requests in both directions with random idle gaps and a
// long response hold-off. Every response beat is checked field by field
// against an in-bench CORDIC predictor, in order of acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_polar_converter_unit_tb;
   import cpc_pkg::*;

   localparam int DW          = DATA_WIDTH_DEF;
   localparam int NITER       = ITERATIONS_DEF;
   localparam int GUARD_BITS  = 24;
   localparam logic [31:0] KINV_Q32 = 32'd2608131496;
   localparam int HOLD_CYCLES = 200;
   localparam int IDLE_LIMIT  = 3000;
   localparam int TAIL_CYCLES = 60;

   localparam logic [31:0] ARCTAN_Q32 [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic        [DW-1:0] radius;
      logic signed [DW-1:0] angle;
      logic                 overflow;
   } conversion_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_operation;
   logic signed [DW-1:0] req_x_coord;
   logic signed [DW-1:0] req_y_coord;
   logic        [DW-1:0] req_radius;
   logic signed [DW-1:0] req_angle;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [DW-1:0] rsp_out_x;
   logic signed [DW-1:0] rsp_out_y;
   logic        [DW-1:0] rsp_out_radius;
   logic signed [DW-1:0] rsp_out_angle;
   logic                 rsp_overflow;

   conversion_type expected_results [$];
   int unsigned mismatch_count;
   int unsigned idle_cycles;
   bit          burst_mode;
   bit          rx_hold_request;
   int unsigned rx_stall_left;

   cartesian_polar_converter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_radius     (req_radius),
      .req_angle      (req_angle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_radius (rsp_out_radius),
      .rsp_out_angle  (rsp_out_angle),
      .rsp_overflow   (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic conversion_type predict_conversion(op_type op,
         logic signed [DW-1:0] px, logic signed [DW-1:0] py,
         logic [DW-1:0] pr, logic signed [DW-1:0] pa);
      conversion_type res;
      longint      cx, cy, cz, dx, dy, lim_hi;
      longint      point [2];
      logic [63:0] mag, hi, lo, rnd, zu, prod;
      bit          flip;
      int          i;
      res = '{x: '0, y: '0, radius: '0, angle: '0, overflow: 1'b0};
      if (op == OP_TO_POLAR) begin
         if (px != 0 || py != 0) begin
            cx = longint'(px) * (longint'(1) << GUARD_BITS);
            cy = longint'(py) * (longint'(1) << GUARD_BITS);
            cz = 0;
            if (cx < 0) begin
               cx = -cx;
               cy = -cy;
               cz = longint'(1) << 31;
            end
            for (i = 0; i < NITER; i++) begin
               dx = cy >>> i;
               dy = cx >>> i;
               if (cy >= 0) begin
                  cx += dx;
                  cy -= dy;
                  cz += longint'(ARCTAN_Q32[i]);
               end else begin
                  cx -= dx;
                  cy += dy;
                  cz -= longint'(ARCTAN_Q32[i]);
               end
            end
            mag = (cx < 0) ? 64'd0 : 64'(cx);
            hi = mag >> 32;
            lo = mag & 64'hFFFF_FFFF;
            mag = hi * 64'(KINV_Q32) + ((lo * 64'(KINV_Q32) + 64'h8000_0000) >> 32);
            rnd = (mag + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
            res.radius = (rnd > ((64'd1 << DW) - 1)) ? '1 : rnd[DW-1:0];
            zu = 64'(cz) & 64'hFFFF_FFFF;
            rnd = (zu + ((64'd1 << (32 - DW)) >> 1)) >> (32 - DW);
            res.angle = rnd[DW-1:0];
         end
      end else begin
         cz = longint'(pa) * (longint'(1) << (32 - DW));
         flip = 1'b0;
         if (cz > (longint'(1) << 30)) begin
            cz -= longint'(1) << 31;
            flip = 1'b1;
         end else if (cz < -(longint'(1) << 30)) begin
            cz += longint'(1) << 31;
            flip = 1'b1;
         end
         prod = 64'(pr) * 64'(KINV_Q32) + (64'd1 << (31 - GUARD_BITS));
         cx = longint'(prod >> (32 - GUARD_BITS));
         if (flip) cx = -cx;
         cy = 0;
         for (i = 0; i < NITER; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
               cx -= dx;
               cy += dy;
               cz -= longint'(ARCTAN_Q32[i]);
            end else begin
               cx += dx;
               cy -= dy;
               cz += longint'(ARCTAN_Q32[i]);
            end
         end
         lim_hi = (longint'(1) << (DW - 1)) - 1;
         point[0] = (cx + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
         point[1] = (cy + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
         for (i = 0; i < 2; i++) begin
            if (point[i] > lim_hi) begin
               point[i] = lim_hi;
               res.overflow = 1'b1;
            end else if (point[i] < -lim_hi - 1) begin
               point[i] = -lim_hi - 1;
               res.overflow = 1'b1;
            end
         end
         res.x = point[0][DW-1:0];
         res.y = point[1][DW-1:0];
      end
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (burst_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DW-1:0] pick_field();
      logic [DW-1:0] corners [9];
      corners = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                  16'h4000, 16'h4001, 16'hC000, 16'hBFFF};
      case ($urandom_range(0, 7))
         0: begin
            return corners[$urandom_range(0, 8)];
         end
         1: begin
            return DW'($urandom_range(0, 15)) - DW'(8);
         end
         default: begin
            return DW'($urandom);
         end
      endcase
   endfunction

   // Called at a falling edge; returns at a falling edge with the beat taken.
   task automatic send_beat(op_type op, logic [DW-1:0] x, logic [DW-1:0] y,
         logic [DW-1:0] r, logic [DW-1:0] a);
      int unsigned gap;
      req_operation = op;
      req_x_coord   = x;
      req_y_coord   = y;
      req_radius    = r;
      req_angle     = a;
      req_valid     = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_conversion(op, x, y, r, a));
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic test_polar_corners();
      send_beat(OP_TO_POLAR, 16'h0000, 16'h0000, 16'h1234, 16'h4321);
      send_beat(OP_TO_POLAR, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_beat(OP_TO_POLAR, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
      send_beat(OP_TO_POLAR, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
      send_beat(OP_TO_POLAR, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
      send_beat(OP_TO_POLAR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      send_beat(OP_TO_POLAR, 16'h8000, 16'h0001, 16'h0000, 16'h0000);
      send_beat(OP_TO_POLAR, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000);
      send_beat(OP_TO_POLAR, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
      send_beat(OP_TO_POLAR, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
   endtask

   task automatic test_cartesian_corners();
      send_beat(OP_TO_CART, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'h7FFF, 16'h4000);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'h7FFF, 16'h4001);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'h7FFF, 16'hC000);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'h7FFF, 16'hBFFF);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'hB505, 16'h2000);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'h0001, 16'hE000);
      send_beat(OP_TO_CART, 16'h0000, 16'h0000, 16'h8000, 16'h8001);
   endtask

   task automatic test_random_stream(int unsigned count);
      int unsigned n;
      for (n = 0; n < count; n++) begin
         burst_mode = (n % 300) >= 260;
         send_beat(op_type'($urandom_range(0, 1)), pick_field(), pick_field(),
                   pick_field(), pick_field());
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_output_backpressure(int unsigned count);
      int unsigned n;
      burst_mode      = 1'b1;
      rx_hold_request = 1'b1;
      for (n = 0; n < count; n++) begin
         send_beat(op_type'($urandom_range(0, 1)), pick_field(), pick_field(),
                   pick_field(), pick_field());
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      rsp_ready     = 1'b0;
      rx_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rx_hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            rx_hold_request = 1'b0;
         end else if (rx_stall_left != 0) begin
            rsp_ready = 1'b0;
            rx_stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (!burst_mode && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      conversion_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_out_x !== want.x) begin
               $display("%0t: out_x expected %0d actual %0d", $time, want.x, rsp_out_x);
               mismatch_count++;
            end
            if (rsp_out_y !== want.y) begin
               $display("%0t: out_y expected %0d actual %0d", $time, want.y, rsp_out_y);
               mismatch_count++;
            end
            if (rsp_out_radius !== want.radius) begin
               $display("%0t: out_radius expected %0d actual %0d", $time, want.radius,
                        rsp_out_radius);
               mismatch_count++;
            end
            if (rsp_out_angle !== want.angle) begin
               $display("%0t: out_angle expected %0d actual %0d", $time, want.angle,
                        rsp_out_angle);
               mismatch_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                        rsp_overflow);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = 1'b0;
      req_x_coord     = '0;
      req_y_coord     = '0;
      req_radius      = '0;
      req_angle       = '0;
      mismatch_count  = 0;
      idle_cycles     = 0;
      burst_mode      = 1'b0;
      rx_hold_request = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_polar_corners();
      test_cartesian_corners();
      test_random_stream(900);
      test_output_backpressure(80);
      test_random_stream(850);

      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
